// ===== sv/lrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lrs_pkg: shared types and constants
// Types and defaults for the base-10 radix sorter core.
// ----------------------------------------------------------------------------
package lrs_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int KEY_BITS_DEF = 31;
    localparam int RADIX        = 10;
    localparam int DIG_BITS     = 4;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CHECK,
        ST_CLR,
        ST_COUNT,
        ST_PREFIX,
        ST_PLACE,
        ST_COPY,
        ST_EMIT,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic start_sort;
        logic clr;
        logic count;
        logic prefix;
        logic place;
        logic copy;
        logic emit;
        logic next_weight;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic more_digits;
        logic scan_end;
        logic set_empty;
        logic emit_end;
    } t_stat;

endpackage

// ===== sv/lrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrs_ctrl: sort sequencer
// Steps load, digit passes (clear, count, prefix, place, copy) and emit.
// ----------------------------------------------------------------------------
module lrs_ctrl import lrs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_last,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output logic  o_ready,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:   if (i_valid && i_last) n_state = ST_CHECK;
            ST_CHECK:  n_state = i_stat.more_digits ? ST_CLR : ST_EMIT;
            ST_CLR:    n_state = ST_COUNT;
            ST_COUNT:  if (i_stat.scan_end) n_state = ST_PREFIX;
            ST_PREFIX: if (i_stat.scan_end) n_state = ST_PLACE;
            ST_PLACE:  if (i_stat.scan_end) n_state = ST_COPY;
            ST_COPY:   if (i_stat.scan_end) n_state = ST_CHECK;
            ST_EMIT:   if (i_stat.set_empty || (i_out_ready && i_stat.emit_end))
                           n_state = ST_DONE;
            ST_DONE:   n_state = ST_LOAD;
            default:   n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_ready     = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            ST_CHECK:  o_cmd.start_sort = 1'b1;
            ST_CLR:    o_cmd.clr = 1'b1;
            ST_COUNT:  o_cmd.count = 1'b1;
            ST_PREFIX: o_cmd.prefix = 1'b1;
            ST_PLACE:  o_cmd.place = 1'b1;
            ST_COPY: begin
                o_cmd.copy        = 1'b1;
                o_cmd.next_weight = i_stat.scan_end;
            end
            ST_EMIT: begin
                o_out_valid = !i_stat.set_empty;
                o_cmd.emit  = i_out_ready;
            end
            ST_DONE:   o_cmd.finish = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== sv/lrs_dp.sv =====
// ----------------------------------------------------------------------------
// lrs_dp: sort datapath
// Key and scratch memories, digit counters, weight register and digit unit.
// ----------------------------------------------------------------------------
module lrs_dp import lrs_pkg::*; #(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [KEY_BITS-1:0] i_key,
    output t_stat               o_stat,
    output logic [KEY_BITS-1:0] o_key,
    output logic                o_last,
    output logic                o_ovf
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = KEY_BITS + 4;

    logic [KEY_BITS-1:0] key_mem [DEPTH];
    logic [KEY_BITS-1:0] scr_mem [DEPTH];
    logic [CW-1:0]       r_cnt [RADIX];
    logic [CW-1:0]       r_loaded;
    logic [KEY_BITS-1:0] r_max;
    logic                r_ovf;
    logic [WW-1:0]       r_weight;
    logic [CW-1:0]       r_idx;
    logic [DIG_BITS-1:0] r_pidx;
    logic [KEY_BITS-1:0] r_rd;
    logic                r_rd_ok;
    logic [KEY_BITS-1:0] r_srd;
    logic                r_srd_ok;
    logic [CW-1:0]       r_wr_idx;

    // Keys are kept with their quotient: quo_mem holds key / weight, so the
    // digit is quo_mem % 10 and the next quotient is quo_mem / 10.
    logic [KEY_BITS-1:0] quo_mem [DEPTH];
    logic [KEY_BITS-1:0] squo_mem [DEPTH];
    logic [KEY_BITS-1:0] r_qrd;
    logic [KEY_BITS-1:0] r_sqrd;

    function automatic logic [DIG_BITS-1:0] mod10(input logic [KEY_BITS-1:0] q);
        logic [KEY_BITS+34:0] p;
        logic [KEY_BITS-1:0]  d;
        logic [KEY_BITS+3:0]  r;
        p = {35'd0, q} * (KEY_BITS+35)'(35'h3333_3334);
        d = KEY_BITS'(p >> 33);
        r = (KEY_BITS+4)'(q) - (KEY_BITS+4)'(d) * (KEY_BITS+4)'(10);
        if (r[KEY_BITS+3]) r = r + (KEY_BITS+4)'(10);
        else if (r >= (KEY_BITS+4)'(10)) r = r - (KEY_BITS+4)'(10);
        return r[DIG_BITS-1:0];
    endfunction

    function automatic logic [KEY_BITS-1:0] div10(input logic [KEY_BITS-1:0] q);
        logic [KEY_BITS-1:0] d;
        logic [KEY_BITS+3:0] r;
        d = KEY_BITS'(({35'd0, q} * (KEY_BITS+35)'(35'h3333_3334)) >> 33);
        r = (KEY_BITS+4)'(q) - (KEY_BITS+4)'(d) * (KEY_BITS+4)'(10);
        if (r[KEY_BITS+3]) d = d - KEY_BITS'(1);
        else if (r >= (KEY_BITS+4)'(10)) d = d + KEY_BITS'(1);
        return d;
    endfunction

    logic [DIG_BITS-1:0] w_dig;
    logic [AW-1:0]       w_pos;
    assign w_dig = mod10(r_qrd);
    assign w_pos = r_cnt[w_dig][AW-1:0] - AW'(1);

    logic [CW-1:0] w_sidx;
    assign w_sidx = r_loaded - r_idx - CW'(1);

    logic w_last_rd;
    assign w_last_rd = (r_idx == r_loaded);

    always_ff @(posedge i_clk) begin
        // memory reads, registered
        if (i_cmd.place) begin
            r_rd  <= key_mem[w_sidx[AW-1:0]];
            r_qrd <= quo_mem[w_sidx[AW-1:0]];
        end else begin
            r_rd  <= key_mem[r_idx[AW-1:0]];
            r_qrd <= quo_mem[r_idx[AW-1:0]];
        end
        r_srd  <= scr_mem[r_idx[AW-1:0]];
        r_sqrd <= squo_mem[r_idx[AW-1:0]];
        r_wr_idx <= r_idx;
        if (i_cmd.load && r_loaded < CW'(DEPTH)) begin
            key_mem[r_loaded[AW-1:0]] <= i_key;
            quo_mem[r_loaded[AW-1:0]] <= i_key;
        end
        if (i_cmd.place && r_rd_ok) begin
            scr_mem[w_pos]  <= r_rd;
            squo_mem[w_pos] <= div10(r_qrd);
        end
        if (i_cmd.copy && r_srd_ok) begin
            key_mem[r_wr_idx[AW-1:0]] <= r_srd;
            quo_mem[r_wr_idx[AW-1:0]] <= r_sqrd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_max    <= '0;
            r_ovf    <= 1'b0;
            r_weight <= WW'(1);
            r_idx    <= '0;
            r_pidx   <= '0;
            r_rd_ok  <= 1'b0;
            r_srd_ok <= 1'b0;
            for (int i = 0; i < RADIX; i++) r_cnt[i] <= '0;
        end else begin
            // read data valid in the cycle after its address
            r_rd_ok  <= (i_cmd.count || i_cmd.place) && !w_last_rd;
            r_srd_ok <= i_cmd.copy && !w_last_rd;
            if (i_cmd.load) begin
                if (r_loaded < CW'(DEPTH)) begin
                    r_loaded <= r_loaded + CW'(1);
                    if (i_key > r_max) r_max <= i_key;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.start_sort) begin
                r_idx  <= '0;
                r_pidx <= DIG_BITS'(1);
            end
            if (i_cmd.clr) begin
                for (int i = 0; i < RADIX; i++) r_cnt[i] <= '0;
                r_idx <= '0;
            end
            // count: read address leads, counter uses registered read
            if (i_cmd.count) begin
                if (!w_last_rd) r_idx <= r_idx + CW'(1);
                if (r_rd_ok) r_cnt[w_dig] <= r_cnt[w_dig] + CW'(1);
                if (o_stat.scan_end) r_idx <= '0;
            end
            if (i_cmd.prefix) begin
                r_cnt[r_pidx] <= r_cnt[r_pidx] + r_cnt[r_pidx - DIG_BITS'(1)];
                if (o_stat.scan_end) r_pidx <= DIG_BITS'(1);
                else r_pidx <= r_pidx + DIG_BITS'(1);
            end
            if (i_cmd.place) begin
                if (!w_last_rd) r_idx <= r_idx + CW'(1);
                if (r_rd_ok) r_cnt[w_dig] <= r_cnt[w_dig] - CW'(1);
                if (o_stat.scan_end) r_idx <= '0;
            end
            if (i_cmd.copy) begin
                if (!w_last_rd) r_idx <= r_idx + CW'(1);
                if (o_stat.scan_end) r_idx <= '0;
            end
            if (i_cmd.next_weight) r_weight <= WW'(r_weight * WW'(10));
            if (i_cmd.emit) r_idx <= r_idx + CW'(1);
            if (i_cmd.finish) begin
                r_loaded <= '0;
                r_max    <= '0;
                r_ovf    <= 1'b0;
                r_weight <= WW'(1);
                r_idx    <= '0;
            end
        end
    end

    // emit prefetch: r_emit_q holds the addressed word; an accepted word
    // moves the read on to the next entry.
    logic [CW-1:0] r_eidx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_eidx <= '0;
        else if (i_cmd.finish) r_eidx <= '0;
        else if (i_cmd.emit) r_eidx <= r_eidx + CW'(1);
    end

    logic [KEY_BITS-1:0] r_emit_q;
    always_ff @(posedge i_clk) begin
        r_emit_q <= key_mem[i_cmd.emit ? AW'(r_eidx + CW'(1)) : r_eidx[AW-1:0]];
    end

    assign o_key  = r_emit_q;
    assign o_last = (r_eidx == r_loaded - CW'(1));
    assign o_ovf  = r_ovf;

    assign o_stat.more_digits = WW'(r_max) >= r_weight;
    assign o_stat.scan_end    = i_cmd.prefix ? (r_pidx == DIG_BITS'(RADIX - 1))
                                             : (w_last_rd && !r_rd_ok && !r_srd_ok
                                                && r_idx == r_loaded);
    assign o_stat.set_empty   = (r_loaded == '0);
    assign o_stat.emit_end    = o_last;

endmodule

// ===== sv/lsd_radix_sort_base10_core.sv =====
// ----------------------------------------------------------------------------
// lsd_radix_sort_base10_core: base-10 LSD radix sorter
// Loads keys, sorts them digit by digit, emits them in ascending order.
// ----------------------------------------------------------------------------
// Loading: one word per cycle. After the last key each digit pass steps
//   through check, clear, count, prefix, place and copy, with
//   digits = decimal length of the largest key; one closing check, then
//   emit at full output rate while i_ready is high; done clears the set.
// One set at a time: no input is taken while sorting or emitting.
// Reset (synchronous, active low) empties the set and returns to loading.
module lsd_radix_sort_base10_core import lrs_pkg::*; #(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [30:0] i_key_value,
    input  logic        i_is_last_key,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [30:0] o_sorted_value,
    output logic        o_is_last_out,
    output logic        o_overflowed
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic [KEY_BITS-1:0] w_key;

    lrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last      (i_is_last_key),
        .i_out_ready (i_ready),
        .i_stat      (w_stat),
        .o_ready     (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (w_cmd)
    );

    lrs_dp #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_key   (i_key_value[KEY_BITS-1:0]),
        .o_stat  (w_stat),
        .o_key   (w_key),
        .o_last  (o_is_last_out),
        .o_ovf   (o_overflowed)
    );

    assign o_sorted_value = 31'(w_key);

    // input only taken while loading
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input ready while emitting");
    // accepted final key stops further input next cycle
    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_is_last_key) |=> !o_ready)
        else $error("ready after last key");

endmodule
